FILE: hdl/pest_pkg.sv
// shared constants and types for the peak energy symbol timing block
// no dependencies; imported by every module of the block
`default_nettype none

package pest_pkg;

   localparam int WINDOW_SIZE_DEFAULT = 16;

   localparam int SAMPLE_W   = 16;
   localparam int PHASE_W    = 8;
   localparam int ENERGY_W   = 16;
   localparam int CFG_W      = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0] LEAK_RATE_RESET  = 16'd2185;
   localparam logic [CFG_W-1:0] LOCK_RATIO_RESET = 16'd63570;

   // register index taken from the word address
   typedef enum logic {
      REG_LEAK_RATE  = 1'b0,
      REG_LOCK_RATIO = 1'b1
   } csr_reg_type;

   // control from the sequencer to the window scan unit
   typedef struct packed {
      logic clear;
      logic beat_vld;
   } scan_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/peak_energy_symbol_timing.sv
// peak energy symbol timing: each input beat is read, leak-multiplied and written back;
// when the beat lands on the evaluation phase a window scan and lock test follow
// before the next beat is taken, so only one beat is in work at a time; the scan reads
// the energy store through its single read port, one entry a cycle
// reset: synchronous; a clearing pass zeroes the energy store
// with req_ready low, configuration writes are taken throughout
`default_nettype none

module peak_energy_symbol_timing #(
   parameter int WINDOW_SIZE = pest_pkg::WINDOW_SIZE_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input channel
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [pest_pkg::SAMPLE_W-1:0]   req_sample,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [pest_pkg::SAMPLE_W-1:0]   rsp_symbol_value,
   output logic             [pest_pkg::PHASE_W-1:0]    rsp_symbol_phase,
   // configuration port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic        [pest_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic        [pest_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic             [pest_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                        csr_pready
);
   import pest_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_SIZE);
   localparam int HALF  = WINDOW_SIZE / 2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);
   localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF);

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,     // zeroing sweep after reset
      ST_IDLE,      // waiting for a sample, read of its energy issued on accept
      ST_MUL,       // leak multiply on the read energy
      ST_WRITE,     // write back, symbol instant and evaluation decision
      ST_SCAN,      // reads of the whole window, one entry a cycle
      ST_LOCK_MUL,  // limit * max, sync phase update
      ST_LOCK_CMP,  // lock decision
      ST_EMIT       // hand the symbol to the result register
   } state_type;

   // control registers
   state_type        state_ff, state_in;
   logic [CFG_W-1:0] leak_rate_ff, leak_rate_in;
   logic [CFG_W-1:0] lock_limit_ff, lock_limit_in;
   logic [IDX_W-1:0] phase_ff, phase_in;
   logic [IDX_W-1:0] sync_ff, sync_in;
   logic [IDX_W-1:0] eval_ff, eval_in;
   logic [IDX_W-1:0] pending_ff, pending_in;
   logic             locked_ff, locked_in;
   logic             symbol_ff, symbol_in;
   logic [IDX_W-1:0] scan_addr_ff, scan_addr_in;   // also the clearing address
   logic             scan_issue_ff, scan_issue_in;
   logic [IDX_W-1:0] tag_ff, tag_in;                // index of the read data in flight
   logic             tag_vld_ff, tag_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_value_ff;
   logic        [PHASE_W-1:0]  rsp_phase_ff;
   logic        [2*CFG_W-1:0]  lock_prod_ff, lock_prod_in;

   // memory and datapath hookup
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic [ENERGY_W-1:0] wr_data, rd_data;
   logic                mul_en;
   logic [ENERGY_W-1:0] new_energy;
   scan_ctl_type        scan_ctl;
   logic [ENERGY_W-1:0] peak, low;
   logic [IDX_W-1:0]    peak_idx;

   // helpers
   logic             req_beat;
   logic             slot_free;
   logic             load_rsp;
   logic             symbol_now;
   logic [IDX_W-1:0] eval_eff;
   logic [IDX_W-1:0] phase_next;
   logic [IDX_W:0]   pending_sum;
   logic [IDX_W-1:0] pending_wrap;
   logic             csr_write;
   csr_reg_type      csr_sel;

   pest_energy_mem #(
      .DEPTH  (WINDOW_SIZE),
      .ADDR_W (IDX_W)
   ) u_energy_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pest_leak_unit u_leak_unit (
      .clock      (clock),
      .mul_en     (mul_en),
      .energy     (rd_data),
      .sample     (sample_ff),
      .leak_rate  (leak_rate_ff),
      .new_energy (new_energy)
   );

   pest_peak_scan #(
      .IDX_W (IDX_W)
   ) u_peak_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .energy   (rd_data),
      .index    (tag_ff),
      .peak     (peak),
      .peak_idx (peak_idx),
      .low      (low)
   );

   // register port: word index from address bit 2, data in the low half
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_sel)
         REG_LEAK_RATE:  csr_prdata = CSR_DATA_W'(leak_rate_ff);
         REG_LOCK_RATIO: csr_prdata = CSR_DATA_W'(lock_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid & req_ready;

   // result register frees up when empty or being taken this cycle
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // symbol instant reloads the evaluation phase before the evaluation check
   assign symbol_now = (phase_ff == sync_ff);
   assign eval_eff   = symbol_now ? pending_ff : eval_ff;
   assign phase_next = (phase_ff == LAST_IDX) ? '0 : phase_ff + 1'b1;

   // next evaluation half a window away from the new peak
   assign pending_sum  = {1'b0, peak_idx} + (IDX_W+1)'(HALF);
   assign pending_wrap = (pending_sum >= (IDX_W+1)'(WINDOW_SIZE))
                         ? IDX_W'(pending_sum - (IDX_W+1)'(WINDOW_SIZE))
                         : IDX_W'(pending_sum);

   assign lock_prod_in = (2*CFG_W)'(lock_limit_ff) * (2*CFG_W)'(peak);

   always_comb begin
      state_in      = state_ff;
      leak_rate_in  = leak_rate_ff;
      lock_limit_in = lock_limit_ff;
      phase_in      = phase_ff;
      sync_in       = sync_ff;
      eval_in       = eval_ff;
      pending_in    = pending_ff;
      locked_in     = locked_ff;
      symbol_in     = symbol_ff;
      scan_addr_in  = scan_addr_ff;
      scan_issue_in = scan_issue_ff;
      tag_in        = scan_addr_ff;
      tag_vld_in    = (state_ff == ST_SCAN) & scan_issue_ff;

      wr_en          = 1'b0;
      wr_addr        = phase_ff;
      wr_data        = new_energy;
      rd_en          = 1'b0;
      rd_addr        = phase_ff;
      mul_en         = 1'b0;
      scan_ctl.clear    = 1'b0;
      scan_ctl.beat_vld = tag_vld_ff;
      load_rsp       = 1'b0;

      if (csr_write) begin
         case (csr_sel)
            REG_LEAK_RATE:  leak_rate_in  = csr_pwdata[CFG_W-1:0];
            REG_LOCK_RATIO: lock_limit_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_addr_ff;
            wr_data = '0;
            if (scan_addr_ff == LAST_IDX) begin
               scan_addr_in = '0;
               state_in     = ST_IDLE;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rd_en    = 1'b1;
               rd_addr  = phase_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en     = 1'b1;
            eval_in   = eval_eff;
            symbol_in = symbol_now;
            if (phase_ff == eval_eff) begin
               // written entry lands before the first scan read
               scan_addr_in   = '0;
               scan_issue_in  = 1'b1;
               scan_ctl.clear = 1'b1;
               state_in       = ST_SCAN;
            end else if (symbol_now & locked_ff & ~slot_free) begin
               state_in = ST_EMIT;
            end else begin
               load_rsp = symbol_now & locked_ff;
               phase_in = phase_next;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_issue_ff) begin
               rd_en   = 1'b1;
               rd_addr = scan_addr_ff;
               if (scan_addr_ff == LAST_IDX) begin
                  scan_issue_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (tag_vld_ff && tag_ff == LAST_IDX) begin
               state_in = ST_LOCK_MUL;
            end
         end
         ST_LOCK_MUL: begin
            if (peak_idx != sync_ff) begin
               sync_in    = peak_idx;
               pending_in = pending_wrap;
            end
            state_in = ST_LOCK_CMP;
         end
         ST_LOCK_CMP: begin
            // an all-zero window counts as ratio zero
            if (peak == '0) begin
               locked_in = (lock_limit_ff != '0);
            end else begin
               locked_in = ({low, {FRAC_W{1'b0}}} < lock_prod_ff);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (~(symbol_ff & locked_ff) | slot_free) begin
               load_rsp = symbol_ff & locked_ff;
               phase_in = phase_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         leak_rate_ff  <= LEAK_RATE_RESET;
         lock_limit_ff <= LOCK_RATIO_RESET;
         phase_ff      <= '0;
         sync_ff       <= '0;
         eval_ff       <= HALF_IDX;
         pending_ff    <= HALF_IDX;
         locked_ff     <= 1'b0;
         symbol_ff     <= 1'b0;
         scan_addr_ff  <= '0;
         scan_issue_ff <= 1'b0;
         tag_ff        <= '0;
         tag_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         leak_rate_ff  <= leak_rate_in;
         lock_limit_ff <= lock_limit_in;
         phase_ff      <= phase_in;
         sync_ff       <= sync_in;
         eval_ff       <= eval_in;
         pending_ff    <= pending_in;
         locked_ff     <= locked_in;
         symbol_ff     <= symbol_in;
         scan_addr_ff  <= scan_addr_in;
         scan_issue_ff <= scan_issue_in;
         tag_ff        <= tag_in;
         tag_vld_ff    <= tag_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_beat) begin
         sample_ff <= req_sample;
      end
      if (state_ff == ST_LOCK_MUL) begin
         lock_prod_ff <= lock_prod_in;
      end
      if (load_rsp) begin
         rsp_value_ff <= sample_ff;
         rsp_phase_ff <= PHASE_W'(phase_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_value = rsp_value_ff;
   assign rsp_symbol_phase = rsp_phase_ff;

endmodule

`default_nettype wire

FILE: hdl/pest_energy_mem.sv
// per-phase energy store: one write port, one read port, registered read data
// depends on pest_pkg
`default_nettype none

module pest_energy_mem #(
   parameter int DEPTH  = pest_pkg::WINDOW_SIZE_DEFAULT,
   parameter int ADDR_W = $clog2(pest_pkg::WINDOW_SIZE_DEFAULT)
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [ADDR_W-1:0]               wr_addr,
   input  wire logic [pest_pkg::ENERGY_W-1:0]   wr_data,
   input  wire logic                            rd_en,
   input  wire logic [ADDR_W-1:0]               rd_addr,
   output logic      [pest_pkg::ENERGY_W-1:0]   rd_data
);
   import pest_pkg::*;

   logic [ENERGY_W-1:0] mem_ff [DEPTH];
   logic [ENERGY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/pest_leak_unit.sv
// leaky energy average: e + ((|s| - e) * alpha) >> 16, one multiply then one add
// depends on pest_pkg
`default_nettype none

module pest_leak_unit (
   input  wire logic                                 clock,
   input  wire logic                                 mul_en,
   input  wire logic        [pest_pkg::ENERGY_W-1:0] energy,
   input  wire logic signed [pest_pkg::SAMPLE_W-1:0] sample,
   input  wire logic        [pest_pkg::CFG_W-1:0]    leak_rate,
   output logic             [pest_pkg::ENERGY_W-1:0] new_energy
);
   import pest_pkg::*;

   localparam int DIFF_W = ENERGY_W + 2;
   localparam int PROD_W = DIFF_W + CFG_W + 1;

   logic signed [SAMPLE_W:0]   sample_ext;
   logic        [SAMPLE_W:0]   mag;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic        [ENERGY_W-1:0] base_in;
   logic        [ENERGY_W-1:0] base_ff;
   logic signed [PROD_W-1:0]   acc;

   always_comb begin
      sample_ext = (SAMPLE_W+1)'(sample);
      // most negative sample gives 32768, still exact in 17 bits
      mag        = sample_ext[SAMPLE_W] ? unsigned'(-sample_ext) : unsigned'(sample_ext);
      diff       = $signed({1'b0, mag}) - $signed({2'b00, energy});
      prod_in    = PROD_W'(diff) * PROD_W'($signed({1'b0, leak_rate}));
      base_in    = energy;
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
   end

   // sum is never negative and below 2^31, so the shift truncates exactly
   assign acc        = $signed({{(PROD_W-ENERGY_W-FRAC_W){1'b0}}, base_ff, {FRAC_W{1'b0}}})
                       + prod_ff;
   assign new_energy = acc[FRAC_W +: ENERGY_W];

endmodule

`default_nettype wire

FILE: hdl/pest_peak_scan.sv
// window scan: first strict maximum with its index, and the minimum, one beat a cycle
// depends on pest_pkg
`default_nettype none

module pest_peak_scan #(
   parameter int IDX_W = $clog2(pest_pkg::WINDOW_SIZE_DEFAULT)
) (
   input  wire logic                          clock,
   input  wire pest_pkg::scan_ctl_type        ctl,
   input  wire logic [pest_pkg::ENERGY_W-1:0] energy,
   input  wire logic [IDX_W-1:0]              index,
   output logic      [pest_pkg::ENERGY_W-1:0] peak,
   output logic      [IDX_W-1:0]              peak_idx,
   output logic      [pest_pkg::ENERGY_W-1:0] low
);
   import pest_pkg::*;

   logic [ENERGY_W-1:0] peak_ff, peak_in;
   logic [IDX_W-1:0]    peak_idx_ff, peak_idx_in;
   logic [ENERGY_W-1:0] low_ff, low_in;

   always_comb begin
      peak_in     = peak_ff;
      peak_idx_in = peak_idx_ff;
      low_in      = low_ff;
      if (ctl.clear) begin
         peak_in     = '0;
         peak_idx_in = '0;
      end else if (ctl.beat_vld) begin
         if (energy > peak_ff) begin
            peak_in     = energy;
            peak_idx_in = index;
         end
         if (index == '0 || energy < low_ff) begin
            low_in = energy;
         end
      end
   end

   always_ff @(posedge clock) begin
      peak_ff     <= peak_in;
      peak_idx_ff <= peak_idx_in;
      low_ff      <= low_in;
   end

   assign peak     = peak_ff;
   assign peak_idx = peak_idx_ff;
   assign low      = low_ff;

endmodule

`default_nettype wire

FILE: hdl/pest_checker.sv
// port-level checks for peak_energy_symbol_timing, bound to the top level
// depends on pest_pkg and peak_energy_symbol_timing
`default_nettype none

module pest_checker #(
   parameter int WINDOW_SIZE = pest_pkg::WINDOW_SIZE_DEFAULT
) (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic signed [pest_pkg::SAMPLE_W-1:0]   req_sample,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [pest_pkg::SAMPLE_W-1:0]   rsp_symbol_value,
   input wire logic        [pest_pkg::PHASE_W-1:0]    rsp_symbol_phase,
   input wire logic                                   csr_psel,
   input wire logic                                   csr_penable,
   input wire logic                                   csr_pwrite,
   input wire logic        [pest_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic        [pest_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic        [pest_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                                   csr_pready
);
   import pest_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_value)
                                  && $stable(rsp_symbol_phase))
      else $error("stalled result beat changed or dropped");

   // clearing pass keeps the input closed right after reset
   a_clear_pass: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input open during clearing pass");

   // one beat at a time: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a beat is in work");

   // a result never appears in the cycle right after an input beat
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result faster than the update pipeline");

   // reported phase lies inside the window
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_symbol_phase) < WINDOW_SIZE))
      else $error("symbol phase outside the window");

endmodule

bind peak_energy_symbol_timing pest_checker #(
   .WINDOW_SIZE (WINDOW_SIZE)
) u_pest_checker (.*);

`default_nettype wire

FILE: tb/sv/peak_energy_symbol_timing_tb.sv
// self-checking bench for peak_energy_symbol_timing: a directed table, then shaped random samples
// over several register settings, every result beat checked against an in-bench timing predictor
// depends on pest_pkg and the peak_energy_symbol_timing rtl
module peak_energy_symbol_timing_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pest_pkg::*;

   localparam int WIN              = WINDOW_SIZE_DEFAULT;
   // worst single beat is the scan beat; the settle wait adds margin on top of it
   localparam int SETTLE_CYCLES    = WIN + 10;
   localparam int STALL_LIMIT      = 3000;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int HOLD_OFF_AT_BEAT = 3;
   localparam int DIRECTED_ROWS    = 25;
   localparam int RANDOM_ITEMS     = 425;
   localparam int SYMBOLS_WANTED   = 40;
   localparam int PHASE_ITEMS      = 64;
   localparam int MAX_PHASES       = 7;
   localparam int PRINT_CAP        = 100;

   // how a stimulus row is checked: by the predictor, or against a typed-in result
   typedef enum logic [1:0] {
      PIN_NONE,
      PIN_QUIET,
      PIN_SYMBOL
   } pin_kind_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic        [PHASE_W-1:0]  phase;
   } symbol_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      pin_kind_type               pin;
      symbol_type                 want;
   } vector_type;

   localparam symbol_type NO_SYMBOL = '0;

   // directed table, row n lands on window phase n modulo the window size since reset
   vector_type directed_rows [DIRECTED_ROWS] = '{
      // silence on phases 0..8: every energy is still zero when the scan at phase 8 runs,
      // so a zero peak counts as locked under the default lock limit
      '{16'sh0000, PIN_QUIET, NO_SYMBOL}, '{16'sh0000, PIN_QUIET, NO_SYMBOL},
      '{16'sh0000, PIN_QUIET, NO_SYMBOL}, '{16'sh0000, PIN_QUIET, NO_SYMBOL},
      '{16'sh0000, PIN_QUIET, NO_SYMBOL}, '{16'sh0000, PIN_QUIET, NO_SYMBOL},
      '{16'sh0000, PIN_QUIET, NO_SYMBOL}, '{16'sh0000, PIN_QUIET, NO_SYMBOL},
      '{16'sh0000, PIN_QUIET, NO_SYMBOL},
      // rest of the window: extremes and bit patterns, sync stays at phase 0 so nothing comes out
      '{16'sh7fff, PIN_QUIET, NO_SYMBOL}, '{16'sh8000, PIN_QUIET, NO_SYMBOL},
      '{16'shffff, PIN_QUIET, NO_SYMBOL}, '{16'sh0001, PIN_QUIET, NO_SYMBOL},
      '{16'sh5555, PIN_QUIET, NO_SYMBOL}, '{16'shaaaa, PIN_QUIET, NO_SYMBOL},
      '{16'sh4000, PIN_QUIET, NO_SYMBOL},
      // back on phase 0 with lock held: the most negative sample is forwarded untouched
      '{16'sh8000, PIN_SYMBOL, '{16'sh8000, 8'd0}},
      // second pass up to the next scan beat, left to the predictor
      '{16'sh8001, PIN_NONE, NO_SYMBOL}, '{16'sh7ffe, PIN_NONE, NO_SYMBOL},
      '{16'shfffe, PIN_NONE, NO_SYMBOL}, '{16'sh0002, PIN_NONE, NO_SYMBOL},
      '{16'sh1234, PIN_NONE, NO_SYMBOL}, '{16'shedcc, PIN_NONE, NO_SYMBOL},
      '{16'sh0064, PIN_NONE, NO_SYMBOL}, '{16'sh0000, PIN_NONE, NO_SYMBOL}
   };

   // register plan for the first random phases, extremes first; later phases draw at random
   int plan_leak  [5] = '{65535,     0, 20000,  2185, 16384};
   int plan_limit [5] = '{65535, 63570,     0, 63570, 50000};

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready   = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_symbol_value;
   logic        [PHASE_W-1:0]    rsp_symbol_phase;
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic        [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic        [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic        [CSR_DATA_W-1:0] csr_prdata;
   logic                         csr_pready;

   // check mode travelling alongside the beat on the input channel
   pin_kind_type                 pin_kind    = PIN_NONE;
   symbol_type                   pin_want    = '0;

   // predictor state and its copy of the registers
   logic [ENERGY_W-1:0]          energy_est [WIN];
   logic [PHASE_W-1:0]           at_phase;
   logic [PHASE_W-1:0]           sync_at;
   logic [PHASE_W-1:0]           eval_at;
   logic [PHASE_W-1:0]           next_eval_at;
   logic                         locked_est;
   logic [CFG_W-1:0]             leak_alpha;
   logic [CFG_W-1:0]             lock_limit;

   symbol_type                   symbols_due [$];
   int                           symbols_total = 0;
   int                           mismatches    = 0;
   int                           fed           = 0;
   int                           beat_spot     = 0;
   int                           send_calm     = 0;
   int                           recv_calm     = 0;
   int                           quiet_cycles  = 0;

   peak_energy_symbol_timing #(
      .WINDOW_SIZE (WIN)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol_value (rsp_symbol_value),
      .rsp_symbol_phase (rsp_symbol_phase),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_CAP) begin
         $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   // one input beat through the energy leak, the window scan and the lock test
   task automatic advance_timing(input logic signed [SAMPLE_W-1:0] s, output logic fired,
                                 output symbol_type sym);
      logic [SAMPLE_W-1:0] raw;
      logic [16:0]         mag;
      logic [63:0]         acc;
      logic [ENERGY_W-1:0] hi;
      logic [ENERGY_W-1:0] lo;
      logic [PHASE_W-1:0]  hi_at;
      logic                instant;
      raw = s;
      // magnitude of the most negative sample is 32768, hence 17 bits
      mag = raw[SAMPLE_W-1] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
      acc = 64'(energy_est[at_phase]) * 64'(17'h10000 - {1'b0, leak_alpha})
          + 64'(mag) * 64'(leak_alpha);
      energy_est[at_phase] = ENERGY_W'(acc >> FRAC_W);
      instant = (at_phase == sync_at);
      if (instant) begin
         eval_at = next_eval_at;
      end
      if (at_phase == eval_at) begin
         hi    = '0;
         hi_at = '0;
         lo    = energy_est[0];
         for (int k = 0; k < WIN; k++) begin
            // first strict maximum wins ties
            if (energy_est[k] > hi) begin
               hi    = energy_est[k];
               hi_at = PHASE_W'(k);
            end
            if (energy_est[k] < lo) begin
               lo = energy_est[k];
            end
         end
         if (hi_at != sync_at) begin
            sync_at      = hi_at;
            next_eval_at = PHASE_W'((hi_at + WIN / 2) % WIN);
         end
         // an all-zero window counts as ratio zero
         if (hi != 0) begin
            locked_est = (64'(lo) << FRAC_W) < 64'(lock_limit) * 64'(hi);
         end else begin
            locked_est = (lock_limit != 0);
         end
      end
      fired    = instant && locked_est;
      sym      = '{s, at_phase};
      at_phase = PHASE_W'((at_phase + 1) % WIN);
   endtask

   // per-beat wait, with calm stretches of back-to-back beats now and then
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
      end
      return $urandom_range(0, 13);
   endfunction

   // mostly a pulse train with one loud phase per window, plus noise, extremes and stray pulses
   function automatic logic signed [SAMPLE_W-1:0] shape_sample();
      logic [SAMPLE_W-1:0] mag;
      int                  pick;
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
         return SAMPLE_W'($urandom);
      end
      if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'shffff;
            default: return 16'sh0000;
         endcase
      end
      if (pick == 9 || (fed % WIN) == beat_spot) begin
         mag = $urandom_range(12000, 32767);
      end else begin
         mag = $urandom_range(0, 1500);
      end
      return ($urandom_range(0, 1) != 0) ? -$signed(mag) : $signed(mag);
   endfunction

   // holds valid with a steady payload until the beat is taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input pin_kind_type pk,
                              input symbol_type want);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      pin_kind   <= pk;
      pin_want   <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fed++;
   endtask

   // apb write then read-back; returns only after psel is dropped, so back-to-back calls never collide
   task automatic program_register(input csr_reg_type which, input logic [CFG_W-1:0] value);
      csr_paddr   <= CSR_ADDR_W'(which) << 2;
      csr_pwdata  <= CSR_DATA_W'(value);
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register taken at that edge; psel stays high into the read setup
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         report_mismatch("register read-back", csr_prdata, value);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (which == REG_LEAK_RATE) begin
         leak_alpha = value;
      end else begin
         lock_limit = value;
      end
      @(posedge clock);
   endtask

   // drop valid, wait out every due symbol, then the scan latency in case a beat is still busy
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (symbols_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result beats are matched first, then the input beat of the same edge is predicted
   always @(posedge clock) begin : monitor
      symbol_type oldest;
      symbol_type est;
      logic       fired;
      if (!reset && rsp_valid && rsp_ready) begin
         if (symbols_due.size() == 0) begin
            report_mismatch("symbol beat with none due, phase", rsp_symbol_phase, -1);
         end else begin
            oldest = symbols_due.pop_front();
            if (rsp_symbol_value !== oldest.value) begin
               report_mismatch("symbol_value", rsp_symbol_value, $signed(oldest.value));
            end
            if (rsp_symbol_phase !== oldest.phase) begin
               report_mismatch("symbol_phase", rsp_symbol_phase, oldest.phase);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         advance_timing(req_sample, fired, est);
         case (pin_kind)
            PIN_NONE: begin
               if (fired) begin
                  symbols_due.push_back(est);
                  symbols_total++;
               end
            end
            PIN_QUIET: begin
               if (fired) begin
                  report_mismatch("predictor fired on a quiet row, phase", est.phase, -1);
               end
            end
            default: begin
               symbols_due.push_back(pin_want);
               symbols_total++;
               if (!fired || est !== pin_want) begin
                  report_mismatch("predictor off a typed-in symbol, phase",
                                  fired ? int'(est.phase) : -1, pin_want.phase);
               end
            end
         endcase
      end
   end

   // result side: random stall per beat, and one long hold-off so the block backs up
   initial begin : receiver
      int gap;
      int beats;
      beats = 0;
      while (reset) @(posedge clock);
      forever begin
         gap = (beats == HOLD_OFF_AT_BEAT) ? HOLD_OFF_CYCLES : pick_gap(recv_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         beats++;
      end
   end

   // ends the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase_no;
      // predictor starts from the reset state
      for (int k = 0; k < WIN; k++) begin
         energy_est[k] = '0;
      end
      at_phase     = '0;
      sync_at      = '0;
      eval_at      = PHASE_W'(WIN / 2);
      next_eval_at = PHASE_W'(WIN / 2);
      locked_est   = 1'b0;
      leak_alpha   = LEAK_RATE_RESET;
      lock_limit   = LOCK_RATIO_RESET;
      phase_no     = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed rows under the reset register values; the clearing pass just holds off ready
      foreach (directed_rows[r]) begin
         send_sample(directed_rows[r].sample, directed_rows[r].pin, directed_rows[r].want);
      end

      // random phases, each under its own register setting and pulse position
      while ((fed < DIRECTED_ROWS + RANDOM_ITEMS || symbols_total < SYMBOLS_WANTED)
             && phase_no < MAX_PHASES) begin
         settle_block();
         if (phase_no < 5) begin
            program_register(REG_LEAK_RATE, CFG_W'(plan_leak[phase_no]));
            program_register(REG_LOCK_RATIO, CFG_W'(plan_limit[phase_no]));
         end else begin
            program_register(REG_LEAK_RATE, CFG_W'($urandom_range(0, 65535)));
            program_register(REG_LOCK_RATIO, CFG_W'($urandom_range(20000, 65535)));
         end
         beat_spot = $urandom_range(0, WIN - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // slow timing drift moves the loud phase and so the sync phase
            if ($urandom_range(0, 63) == 0) begin
               beat_spot = (beat_spot + 1) % WIN;
            end
            send_sample(shape_sample(), PIN_NONE, NO_SYMBOL);
         end
         phase_no++;
      end

      settle_block();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
